@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/wwgs_pkg.sv @@
// ----------------------------------------------------------------------------
// wwgs_pkg
// Types, codes and helpers of the Wireworld grid stepper.
// ----------------------------------------------------------------------------
package wwgs_pkg;

	// Default grid capacity
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	// Field and register widths
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ROW_IDX_W = 6;
	localparam int COL_IDX_W = 6;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;
	localparam logic [CFG_W-1:0]     ROWS_RST      = 7'd30;
	localparam logic [CFG_W-1:0]     COLS_RST      = 7'd40;

	typedef enum logic [1:0] {
		CELL_EMPTY = 2'd0,
		CELL_WIRE  = 2'd1,
		CELL_HEAD  = 2'd2,
		CELL_TAIL  = 2'd3
	} cell_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t                  command;
		logic [ROW_IDX_W-1:0]  row_index;
		logic [COL_IDX_W-1:0]  col_index;
		cell_t                 cell_value;
	} in_beat_t;

	typedef struct packed {
		cell_t cell_state;
		logic  is_read_reply;
	} out_beat_t;

	// Next generation of one cell given its neighbor head count
	function automatic cell_t wire_next(cell_t cur, logic [3:0] heads);
		cell_t nxt;
		nxt = cur;
		case (cur)
			CELL_HEAD: nxt = CELL_TAIL;
			CELL_TAIL: nxt = CELL_WIRE;
			CELL_WIRE: nxt = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
			default:   nxt = cur;
		endcase
		return nxt;
	endfunction

endpackage

@@ hw/rtl/wireworld_grid_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// wireworld_grid_stepper_unit
// Wireworld grid held in a cell memory; write, read, clear and step commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one command per beat.
//   Output channel (out_valid / out_stall / out_data) returns exactly one beat
//   per command: read replies carry the cell, all others are acknowledgements.
//   Config port (cfg_we / cfg_index / cfg_data) sets grid_rows and grid_cols;
//   write it only while the block is idle. Sizes above the capacity saturate.
// Clear sweeps all MAX_ROWS*MAX_COLS entries; step scans (rows+1)*(cols+1)
//   positions, one cell memory access per cycle, with one row and one
//   column of lead-in for the 3x3 window.
// One command is in work at a time; the next is accepted as soon as the
// previous result sits in the output register.
// Reset: the cell memory is swept to empty, one entry per cycle, over all
//   MAX_ROWS*MAX_COLS entries (4096 by default); in_stall stays high meanwhile.
// A stalled result holds in the output register; the block then finishes at
//   most one more command and waits with in_stall high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wireworld_grid_stepper_unit
	import wwgs_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = $clog2(DEPTH);
	localparam int BASE_W = AW + 1;
	localparam int XW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int CW     = $clog2(MAX_COLS + 1);
	localparam int RC_W   = (RW > CW) ? RW : CW;
	localparam int DIM_W  = (RC_W > CFG_W) ? RC_W : CFG_W;

	// Config registers
	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROWS_RST;
			grid_cols_q <= COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated grid size
	logic [DIM_W-1:0] rows_use, cols_use;

	assign rows_use = (DIM_W'(grid_rows_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
		: DIM_W'(grid_rows_q);
	assign cols_use = (DIM_W'(grid_cols_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
		: DIM_W'(grid_cols_q);

	// Command decode
	logic          in_accept, cmd_inside, size_zero;
	logic [AW-1:0] cmd_addr;

	assign in_accept  = in_valid && !in_stall;
	assign cmd_inside = (DIM_W'(in_data.row_index) < rows_use)
		&& (DIM_W'(in_data.col_index) < cols_use);
	assign size_zero  = (rows_use == '0) || (cols_use == '0);
	assign cmd_addr   = AW'(in_data.row_index) * AW'(MAX_COLS) + AW'(in_data.col_index);

	// State and control registers
	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [DIM_W-1:0]  p_q, x_q;
	logic [BASE_W-1:0] base_q;
	logic              issue_done_q;
	logic              out_valid_q;
	out_beat_t         out_data_q, res_q;
	logic              rd_inside_q;

	// Step pipeline tags
	logic              v_s1, first_s1, col_ok_s1, top_ok_s1, mid_ok_s1, bot_ok_s1;
	logic              wr_ok_s1, v_s2, wr_ok_s2;
	logic [XW-1:0]     x_s1;
	logic [BASE_W-1:0] addr_s1, addr_s2;

	// Memories and read data
	cell_t             cell_mem [DEPTH];
	cell_t             mem_rdata_q;
	logic [3:0]        lb_mem [MAX_COLS];
	logic [3:0]        lb_rdata_q;

	logic              mem_we, lb_we, issue, out_free, clr_last, step_end;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	cell_t             mem_wdata;
	logic [BASE_W-1:0] step_raddr, step_waddr;
	cell_t             new_col [3];
	logic [3:0]        heads;
	cell_t             win_q [3][3];

	assign out_free   = !out_valid_q || !out_stall;
	assign clr_last   = (clr_q == AW'(DEPTH - 1));
	assign issue      = (state_q == ST_STEP) && !issue_done_q;
	assign step_end   = issue_done_q && !v_s1 && !v_s2;
	assign step_raddr = base_q + BASE_W'(x_q);
	assign step_waddr = addr_s2 - BASE_W'(MAX_COLS + 1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:  if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.command)
						CMD_WRITE: state_d = ST_DONE;
						CMD_READ:  state_d = ST_READ;
						CMD_STEP:  state_d = size_zero ? ST_DONE : ST_STEP;
						CMD_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_READ:  state_d = ST_DONE;
			ST_STEP:  if (step_end) state_d = ST_DONE;
			ST_CLEAR: if (clr_last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_INIT;
		endcase
	end

	// Outputs of the state machine: memory ports and input stall
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = CELL_EMPTY;
		mem_raddr = cmd_addr;
		lb_we     = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_we    = in_valid && (in_data.command == CMD_WRITE) && cmd_inside;
				mem_waddr = cmd_addr;
				mem_wdata = in_data.cell_value;
			end
			ST_STEP: begin
				mem_raddr = step_raddr[AW-1:0];
				mem_we    = v_s2 && wr_ok_s2;
				mem_waddr = step_waddr[AW-1:0];
				mem_wdata = wire_next(win_q[1][1], heads);
				lb_we     = v_s1 && col_ok_s1;
			end
			default: ;
		endcase
	end

	// Cell memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= cell_mem[mem_raddr];
	end

	// Old-row buffer: each entry holds {row p-1, row p} of one column
	always_ff @(posedge clk) begin
		if (lb_we) lb_mem[x_s1] <= {new_col[1], new_col[2]};
		lb_rdata_q <= lb_mem[x_q[XW-1:0]];
	end

	// Incoming window column, outside cells masked to empty
	always_comb begin
		new_col[0] = (top_ok_s1 && col_ok_s1) ? cell_t'(lb_rdata_q[3:2]) : CELL_EMPTY;
		new_col[1] = (mid_ok_s1 && col_ok_s1) ? cell_t'(lb_rdata_q[1:0]) : CELL_EMPTY;
		new_col[2] = (bot_ok_s1 && col_ok_s1) ? mem_rdata_q : CELL_EMPTY;
	end

	// 3x3 window shifts one column per beat
	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= first_s1 ? CELL_EMPTY : win_q[1][r];
				win_q[1][r] <= first_s1 ? CELL_EMPTY : win_q[2][r];
				win_q[2][r] <= new_col[r];
			end
		end
	end

	// Heads around the window center
	always_comb begin
		heads = 4'd0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (!(c == 1 && r == 1) && win_q[c][r] == CELL_HEAD) heads = heads + 4'd1;
			end
		end
	end

	// Step pipeline payload tags
	always_ff @(posedge clk) begin
		first_s1  <= (x_q == '0);
		col_ok_s1 <= (x_q < cols_use);
		top_ok_s1 <= (p_q >= DIM_W'(2));
		mid_ok_s1 <= (p_q != '0);
		bot_ok_s1 <= (p_q < rows_use);
		wr_ok_s1  <= (p_q != '0) && (x_q != '0);
		x_s1      <= x_q[XW-1:0];
		addr_s1   <= step_raddr;
		wr_ok_s2  <= wr_ok_s1;
		addr_s2   <= addr_s1;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q.cell_state    <= CELL_EMPTY;
			res_q.is_read_reply <= (in_data.command == CMD_READ);
			rd_inside_q         <= cmd_inside;
		end else if (state_q == ST_READ) begin
			res_q.cell_state <= rd_inside_q ? mem_rdata_q : CELL_EMPTY;
		end
		if (state_q == ST_DONE && out_free) out_data_q <= res_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			clr_q        <= '0;
			p_q          <= '0;
			x_q          <= '0;
			base_q       <= '0;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;

			// clearing sweep
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end

			// step scan: row p read, row p-1 written
			if (in_accept) begin
				p_q          <= '0;
				x_q          <= '0;
				base_q       <= '0;
				issue_done_q <= 1'b0;
			end else if (issue) begin
				if (x_q == cols_use) begin
					x_q    <= '0;
					p_q    <= p_q + DIM_W'(1);
					base_q <= base_q + BASE_W'(MAX_COLS);
					if (p_q == rows_use) issue_done_q <= 1'b1;
				end else begin
					x_q <= x_q + DIM_W'(1);
				end
			end

			// output register
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Step write never hits the cell being read in the same cycle
	`ASSERT_IMPLY(a_step_no_clash, clk, arst_n, issue && v_s2 && wr_ok_s2, step_waddr != step_raddr)
	// A finished result waits while the output register is stalled
	`ASSERT_NEXT(a_done_holds, clk, arst_n, state_q == ST_DONE && out_valid_q && out_stall, state_q == ST_DONE)
	// A step keeps running until its scan has been issued
	`ASSERT_NEXT(a_step_runs, clk, arst_n, state_q == ST_STEP && !issue_done_q, state_q == ST_STEP)
	// An accepted read moves to ST_READ to wait for the registered cell memory read
	`ASSERT_NEXT(a_read_wait, clk, arst_n, in_accept && in_data.command == CMD_READ, state_q == ST_READ)

endmodule
